### src/chirp_tone_generator_defines.svh
// assertion macros for the chirp tone generator
`ifndef CHIRP_TONE_GENERATOR_DEFINES_SVH
`define CHIRP_TONE_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CTG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ctg_pkg.sv
// shared constants, register codes and quarter-wave sine table for the chirp tone generator
`default_nettype none

package ctg_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int SINE_W     = 15;

  localparam int FREQ_W    = 14;
  localparam int SLIDE_W   = 15;
  localparam int VOL_W     = 16;
  localparam int FRAMES_W  = 16;
  localparam int TIME_W    = 25;
  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SLIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_VOLUME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd4;

  localparam logic [FREQ_W-1:0]         RST_START_FREQ  = 14'd440;
  localparam logic signed [SLIDE_W-1:0] RST_FREQ_SLIDE  = 15'sd0;
  localparam logic [VOL_W-1:0]          RST_TONE_VOLUME = 16'd16384;
  localparam logic [FRAMES_W-1:0]       RST_FRAME_COUNT = 16'd2205;
  localparam logic [TIME_W-1:0]         RST_TIME_STEP   = 25'd7609;

  localparam logic [TIME_W-1:0] ONE_Q24 = 25'h100_0000;

  // frequency sum in Q.24, floored at 20 Hz
  localparam int FQ_W = 39;
  localparam logic signed [FQ_W+1:0] FQ_FLOOR = 41'sd335544320;

  // phase increment = floor(fq * 256 / 22050), radix-16 restoring division
  localparam int DIV_DIGIT_W = 4;
  localparam int DIV_STEPS   = 12;
  localparam int DIVIDEND_W  = DIV_DIGIT_W * DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int REM_W       = 15;
  localparam logic [REM_W:0] RATE_HZ = 16'd22050;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({1'b0, x});
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - $signed({1'b0, term});
      end else begin
        sum = sum + $signed({1'b0, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > 65'sd1073741824) begin
      sum = 65'sd1073741824;
    end
    return sum[63:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] s;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x      = (64'(2 * k + 1) * PI_Q30) / 64'(4 * SINE_DEPTH);
      s      = sin_q30(x);
      rom[k] = SINE_W'((s * 64'd32767 + 64'd536870912) >> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### src/chirp_tone_generator.sv
// chirp tone generator top level: sequencer, shared multiplier, divider and sine lookup
// Usage:
// Each transaction on the input channel (in_valid, in_stall, in_restart) asks for one
// audio sample; in_restart clears sample index, phase and time before that sample.
// Each input transaction gives exactly one output transaction (out_sample, out_last,
// out_done_res). out_last marks the final sample of the tone; once the tone is over
// the block returns zero samples with out_done_res set until a restart.
// Registers are written through cfg_we, cfg_index and cfg_wdata, by the user only while
// no sample is in flight (the block does not enforce it); unknown indexes are ignored.
// Timing: the next transaction is taken only once the sample is in the output register,
// so the block works on one sample at a time. The phase increment comes from the
// radix-16 division by the sample rate; four products go through one shared 33x26
// multiplier. A sample after the tone ends skips the division and the products.
// in_stall is high while a sample is in work. The result sits in an output register,
// so a new transaction is taken while it waits; a second result holds in the last
// step until out_stall drops.
// Reset (rst_n low, synchronous) restores the register defaults and clears index,
// phase, time and the output valid.
`default_nettype none
`include "chirp_tone_generator_defines.svh"

module chirp_tone_generator
  import ctg_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_restart,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  output logic                            out_last,
  output logic                            out_done_res
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CHECK    = 11'b000_0000_0010,
    S_FREQ     = 11'b000_0000_0100,
    S_DIVINIT  = 11'b000_0000_1000,
    S_DIV      = 11'b000_0001_0000,
    S_PHASE    = 11'b000_0010_0000,
    S_LOOK     = 11'b000_0100_0000,
    S_MUL_ENV  = 11'b000_1000_0000,
    S_MUL_FALL = 11'b001_0000_0000,
    S_MUL_VOL  = 11'b010_0000_0000,
    S_FIN      = 11'b100_0000_0000
  } state_t;

  // control state
  state_t                      state_r, state_nxt;
  logic [FREQ_W-1:0]           start_freq_r;
  logic signed [SLIDE_W-1:0]   freq_slide_r;
  logic [VOL_W-1:0]            tone_volume_r;
  logic [FRAMES_W-1:0]         frame_count_r;
  logic [TIME_W-1:0]           time_step_r;
  logic [FRAMES_W-1:0]         idx_r, idx_nxt;
  logic [PHASE_W-1:0]          phase_r, phase_nxt;
  logic [TIME_W-1:0]           tf_r, tf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0]        cnt_r, cnt_nxt;

  // datapath
  logic [TIME_W-1:0]           t_r, t_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic [DIVIDEND_W-1:0]       div_r, div_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [PHASE_W-1:0]          quo_r, quo_nxt;
  logic [SINE_W-1:0]           mag_r, mag_nxt;
  logic [SINE_W-1:0]           env_r, env_nxt;
  logic                        neg_r, neg_nxt;
  logic [SAMPLE_W-1:0]         out_sample_r, out_sample_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_done_r, out_done_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic [TIME_W-1:0]           t_clamp;
  logic signed [FQ_W+1:0]      fq_sum;
  logic [FQ_W-1:0]             fq_clamped;
  logic [REM_W-1:0]            rem_step;
  logic [DIV_DIGIT_W-1:0]      digit;
  logic [TIME_W+2:0]           rise;
  logic [TIME_W-1:0]           rise_c;
  logic [TIME_W+5:0]           env_ph;
  logic [SINE_AW-1:0]          ph_pos;
  logic [SINE_AW-1:0]          env_pos;
  logic [TIME_W-1:0]           omt;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_full;
  logic [45:0]                 vol_clamped;
  logic [60:0]                 scaled;
  logic [SAMPLE_W-1:0]         sample_abs;
  logic [SAMPLE_W-1:0]         sample_fin;
  logic                        last_fin;
  logic [TIME_W:0]             tf_sum;

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_last     = out_last_r;
  assign out_done_res = out_done_r;

  // time clamped to one, frequency sum with 20 Hz floor
  assign t_clamp    = (tf_r > ONE_Q24) ? ONE_Q24 : tf_r;
  assign fq_sum     = $signed({3'b000, start_freq_r, 24'h00_0000}) + $signed(prod_r[FQ_W+1:0]);
  assign fq_clamped = (fq_sum < FQ_FLOOR) ? FQ_FLOOR[FQ_W-1:0] : fq_sum[FQ_W-1:0];

  // one radix-16 digit of the division by the sample rate
  always_comb begin
    logic [REM_W:0] trial;
    rem_step = rem_r;
    digit    = '0;
    trial    = '0;
    for (int i = 0; i < DIV_DIGIT_W; i++) begin
      trial = {rem_step, div_r[DIVIDEND_W-1-i]};
      if (trial >= RATE_HZ) begin
        rem_step                 = REM_W'(trial - RATE_HZ);
        digit[DIV_DIGIT_W-1-i]   = 1'b1;
      end else begin
        rem_step = trial[REM_W-1:0];
      end
    end
  end

  // quarter-wave addressing for tone phase and envelope rise
  assign rise    = {t_r, 3'b000};
  assign rise_c  = (rise > {3'b000, ONE_Q24}) ? ONE_Q24 : rise[TIME_W-1:0];
  assign env_ph  = {rise_c, 6'b00_0000};
  assign ph_pos  = phase_r[29 -: SINE_AW] ^ {SINE_AW{phase_r[30]}};
  assign env_pos = env_ph[29 -: SINE_AW] ^ {SINE_AW{env_ph[30]}};
  assign omt     = ONE_Q24 - t_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FREQ: begin
        mul_a = MUL_A_W'(freq_slide_r);
        mul_b = $signed({1'b0, t_r});
      end
      S_MUL_ENV: begin
        mul_a = $signed({18'h0_0000, mag_r});
        mul_b = $signed({11'h000, env_r});
      end
      S_MUL_FALL: begin
        mul_a = $signed({3'b000, prod_r[29:0]});
        mul_b = $signed({1'b0, omt});
      end
      S_MUL_VOL: begin
        mul_a = $signed({2'b00, prod_r[54:24]});
        mul_b = $signed({10'h000, tone_volume_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // volume clamp, scale by 32767, sign
  assign vol_clamped = (prod_r[46:0] > 47'h2000_0000_0000) ? 46'h2000_0000_0000
                                                           : prod_r[45:0];
  assign scaled      = {vol_clamped, 15'h0000} - {15'h0000, vol_clamped};
  assign sample_abs  = {1'b0, scaled[59:45]};
  assign sample_fin  = neg_r ? (16'h0000 - sample_abs) : sample_abs;
  assign last_fin    = ({1'b0, idx_r} + 17'd1) == {1'b0, frame_count_r};
  assign tf_sum      = {1'b0, tf_r} + {1'b0, time_step_r};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    tf_nxt         = tf_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    t_nxt          = t_r;
    prod_nxt       = prod_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    mag_nxt        = mag_r;
    env_nxt        = env_r;
    neg_nxt        = neg_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_restart) begin
            idx_nxt   = '0;
            phase_nxt = '0;
            tf_nxt    = '0;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (idx_r >= frame_count_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_sample_nxt = '0;
            out_last_nxt   = 1'b0;
            out_done_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          t_nxt     = t_clamp;
          state_nxt = S_FREQ;
        end
      end
      S_FREQ: begin
        prod_nxt  = prod_full;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        div_nxt   = DIVIDEND_W'({fq_clamped, 8'h00});
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_step;
        div_nxt = div_r << DIV_DIGIT_W;
        quo_nxt = {quo_r[PHASE_W-DIV_DIGIT_W-1:0], digit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        phase_nxt = phase_r + quo_r;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        mag_nxt   = SINE_ROM[ph_pos];
        env_nxt   = SINE_ROM[env_pos];
        neg_nxt   = phase_r[31];
        state_nxt = S_MUL_ENV;
      end
      S_MUL_ENV: begin
        prod_nxt  = prod_full;
        state_nxt = S_MUL_FALL;
      end
      S_MUL_FALL: begin
        prod_nxt  = prod_full;
        state_nxt = S_MUL_VOL;
      end
      S_MUL_VOL: begin
        prod_nxt  = prod_full;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sample_fin;
          out_last_nxt   = last_fin;
          out_done_nxt   = 1'b0;
          idx_nxt        = idx_r + 1'b1;
          tf_nxt         = tf_sum[TIME_W] ? {TIME_W{1'b1}} : tf_sum[TIME_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      phase_r       <= '0;
      tf_r          <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      start_freq_r  <= RST_START_FREQ;
      freq_slide_r  <= RST_FREQ_SLIDE;
      tone_volume_r <= RST_TONE_VOLUME;
      frame_count_r <= RST_FRAME_COUNT;
      time_step_r   <= RST_TIME_STEP;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      tf_r        <= tf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_FREQ:  start_freq_r  <= cfg_wdata[FREQ_W-1:0];
          CFG_FREQ_SLIDE:  freq_slide_r  <= $signed(cfg_wdata[SLIDE_W-1:0]);
          CFG_TONE_VOLUME: tone_volume_r <= cfg_wdata[VOL_W-1:0];
          CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[FRAMES_W-1:0];
          CFG_TIME_STEP:   time_step_r   <= cfg_wdata[TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    prod_r       <= prod_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    mag_r        <= mag_nxt;
    env_r        <= env_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
  end

  `CTG_ASSERT_IMPLIES(a_done_zero, out_valid && out_done_res, out_sample == '0 && !out_last, "finished tone must give a silent non-final sample")
  `CTG_ASSERT_NEXT(a_time_no_drop, !(in_acc && in_restart), tf_r >= $past(tf_r), "time fraction dropped without restart")
  `CTG_ASSERT_NEXT(a_phase_hold, state_r != S_PHASE && !(in_acc && in_restart), phase_r == $past(phase_r), "phase moved outside its update step")

endmodule

`default_nettype wire

### dv/tb_chirp_tone_generator.sv
// self-checking testbench for chirp_tone_generator: random config phases, restarts and back-pressure
module tb_chirp_tone_generator;
  import ctg_pkg::*;

  localparam int RUN_LIMIT = 1000000;
  localparam int RAND_ITEMS = 1800;
  localparam int MAX_PRINTS = 200;
  localparam logic [63:0] PI_FX30 = 64'd3373259426;
  localparam logic [63:0] ONE_T = 64'd16777216;
  localparam logic [63:0] T_SAT = 64'h1FF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_TIME_STEP + 3'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic last;
    logic done;
  } tone_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic out_last;
  logic out_done_res;

  chirp_tone_generator u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .out_last(out_last),
    .out_done_res(out_done_res)
  );

  always #2 clk = ~clk;

  // register mirror
  logic [FREQ_W-1:0] cur_start = RST_START_FREQ;
  logic signed [SLIDE_W-1:0] cur_slide = RST_FREQ_SLIDE;
  logic [VOL_W-1:0] cur_volume = RST_TONE_VOLUME;
  logic [FRAMES_W-1:0] cur_frames = RST_FRAME_COUNT;
  logic [TIME_W-1:0] cur_step = RST_TIME_STEP;

  // tone state mirror
  logic [FRAMES_W-1:0] tone_idx = '0;
  logic [PHASE_W-1:0] tone_phase = '0;
  logic [TIME_W-1:0] tone_time = '0;
  int sine_tbl [SINE_DEPTH];

  logic pending_restarts [$];
  tone_t tone_q [$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int idle_mode = 0;
  int gap_left = 0;
  int stall_left = 0;
  int rand_items = 0;

  function automatic logic [63:0] taylor_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [64:0] acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = $signed({1'b0, x});
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed({1'b0, term});
      end else begin
        acc = acc + $signed({1'b0, term});
      end
    end
    if (acc < 0) acc = '0;
    if (acc > 65'sd1073741824) acc = 65'sd1073741824;
    return acc[63:0];
  endfunction

  function automatic int wave_at(input logic [PHASE_W-1:0] ph);
    logic [63:0] pos;
    int v;
    pos = ({34'd0, ph[29:0]} * 64'(SINE_DEPTH)) >> 30;
    if (pos >= 64'(SINE_DEPTH)) pos = 64'(SINE_DEPTH - 1);
    if (ph[30]) pos = 64'(SINE_DEPTH - 1) - pos;
    v = sine_tbl[pos[SINE_AW-1:0]];
    return ph[31] ? -v : v;
  endfunction

  task automatic predict_sample(input logic restart);
    tone_t want;
    logic [63:0] t;
    logic [63:0] rise;
    logic [63:0] mag;
    logic [63:0] env;
    logic [63:0] incr;
    logic [63:0] nt;
    logic signed [63:0] fq;
    logic signed [63:0] slide_w;
    int s;
    logic neg;
    if (restart) begin
      tone_idx = '0;
      tone_phase = '0;
      tone_time = '0;
    end
    want = '0;
    if (tone_idx >= cur_frames) begin
      want.done = 1'b1;
    end else begin
      t = 64'(tone_time);
      if (t > ONE_T) t = ONE_T;
      slide_w = cur_slide;
      fq = $signed(64'(cur_start)) * $signed(ONE_T) + slide_w * $signed(t);
      if (fq < 64'sd335544320) fq = 64'sd335544320;
      incr = (64'(fq) * 64'd256) / 64'd22050;
      tone_phase = tone_phase + incr[PHASE_W-1:0];
      s = wave_at(tone_phase);
      neg = s < 0;
      mag = neg ? 64'(-s) : 64'(s);
      rise = t * 64'd8;
      if (rise > ONE_T) rise = ONE_T;
      env = 64'(wave_at(32'(rise << 6)));
      mag = mag * env;
      mag = (mag * (ONE_T - t)) >> 24;
      mag = mag * 64'(cur_volume);
      if (mag > (64'd1 << 45)) mag = 64'd1 << 45;
      mag = (mag * 64'd32767) >> 45;
      want.sample = neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
      want.last = ({1'b0, tone_idx} + 17'd1) == {1'b0, cur_frames};
      tone_idx = tone_idx + 1'b1;
      nt = 64'(tone_time) + 64'(cur_step);
      if (nt > T_SAT) nt = T_SAT;
      tone_time = nt[TIME_W-1:0];
    end
    tone_q = {tone_q, want};
  endtask

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < MAX_PRINTS) begin
      $display("[%0d] mismatch %s: got %0d, want %0d", cycle_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  task automatic add_pending(input logic restart);
    pending_restarts = {pending_restarts, restart};
  endtask

  task automatic check_sample();
    tone_t want;
    if (tone_q.size() == 0) begin
      report_mismatch("unexpected sample", int'(out_sample), 0);
    end else begin
      want = tone_q.pop_front();
      if (out_sample !== want.sample) report_mismatch("sample", out_sample, want.sample);
      if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      if (out_done_res !== want.done) report_mismatch("done_res", out_done_res, want.done);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sample(in_restart);
        void'(pending_restarts.pop_front());
        gap_left = pick_gap(idle_mode);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_restarts.size() > 0) begin
          in_valid <= 1'b1;
          in_restart <= pending_restarts[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_sample();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(idle_mode);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_restarts.size() != 0 || tone_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    case (idx)
      CFG_START_FREQ: begin
        cfg_wdata <= {junk[CFG_W-1:FREQ_W], value[FREQ_W-1:0]};
        cur_start = value[FREQ_W-1:0];
      end
      CFG_FREQ_SLIDE: begin
        cfg_wdata <= {junk[CFG_W-1:SLIDE_W], value[SLIDE_W-1:0]};
        cur_slide = value[SLIDE_W-1:0];
      end
      CFG_TONE_VOLUME: begin
        cfg_wdata <= {junk[CFG_W-1:VOL_W], value[VOL_W-1:0]};
        cur_volume = value[VOL_W-1:0];
      end
      CFG_FRAME_COUNT: begin
        cfg_wdata <= {junk[CFG_W-1:FRAMES_W], value[FRAMES_W-1:0]};
        cur_frames = value[FRAMES_W-1:0];
      end
      CFG_TIME_STEP: begin
        cfg_wdata <= value;
        cur_step = value;
      end
      default: cfg_wdata <= junk;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_tone(input int start, input int slide, input int vol, input int frames,
                          input int step);
    wait_drained();
    write_reg(CFG_START_FREQ, CFG_W'(start));
    write_reg(CFG_FREQ_SLIDE, CFG_W'(slide));
    write_reg(CFG_TONE_VOLUME, CFG_W'(vol));
    write_reg(CFG_FRAME_COUNT, CFG_W'(frames));
    write_reg(CFG_TIME_STEP, CFG_W'(step));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 2)), '0);
    end
    close_writes();
  endtask

  task automatic queue_tone(input int n, input logic first_restart, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      add_pending(i == 0 ? first_restart : ($urandom_range(0, 99) < noise_pct));
    end
  endtask

  initial begin
    int frames;
    int step;
    int start;
    int vol;
    int n;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      sine_tbl[k] = int'((taylor_sin((64'(2 * k + 1) * PI_FX30) / 64'(4 * SINE_DEPTH))
                          * 64'd32767 + 64'd536870912) >> 30);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults, then extremes and corner cases
    queue_tone(4, 1'b1, 0);
    idle_mode = 1;
    set_tone(0, -16384, 65535, 3, 33554431);
    queue_tone(5, 1'b1, 0);
    set_tone(16383, 16383, 65535, 4, 8388608);
    queue_tone(5, 1'b1, 0);
    add_pending(1'b1);
    set_tone(11025, 11025, 32768, 0, 16777216);
    add_pending(1'b0);
    add_pending(1'b1);
    set_tone(11025, -11025, 32768, 6, 2796203);
    queue_tone(3, 1'b1, 0);
    wait_drained();
    // shorten the tone below the current index
    write_reg(CFG_FRAME_COUNT, CFG_W'(2));
    write_reg(CFG_UNUSED_LO, '1);
    write_reg(CFG_UNUSED_LO + 3'd2, '1);
    close_writes();
    queue_tone(2, 1'b0, 0);
    set_tone(20, 0, 32768, 2, 0);
    queue_tone(2, 1'b1, 0);

    // random tones, mostly short well-formed ones
    while (rand_items < RAND_ITEMS) begin
      n = $urandom_range(0, 99);
      if (n < 70) frames = $urandom_range(1, 48);
      else if (n < 90) frames = $urandom_range(49, 400);
      else if (n < 94) frames = 0;
      else if (n < 97) frames = 65535;
      else frames = $urandom_range(0, 65535);
      n = $urandom_range(0, 99);
      if (frames > 0 && n < 75) step = (16777216 + frames / 2) / frames;
      else if (n < 85) step = 16777216;
      else step = $urandom_range(0, 33554431);
      start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 11025);
      n = $urandom_range(0, 9);
      vol = (n == 0) ? 32768 : (n == 1) ? 0 : $urandom_range(0, 65535);
      set_tone(start, $urandom_range(0, 32767), vol, frames, step);
      idle_mode = $urandom_range(0, 3);
      if (frames > 0 && frames <= 48) n = frames + $urandom_range(1, 6);
      else n = $urandom_range(20, 80);
      queue_tone(n, $urandom_range(0, 9) != 0, ($urandom_range(0, 3) == 0) ? 8 : 0);
      rand_items += n;
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/ctg_pkg.sv
src/chirp_tone_generator.sv
dv/tb_chirp_tone_generator.sv
